### rtl/dqdm_pkg.sv
// Shared types, constants and step table for the dual quadrature decoder.
package dqdm_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 2;
   localparam int INTERVAL_W           = 8;
   localparam int TIME_W               = 32;
   localparam int POS_W                = 8;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd2;

   localparam logic signed [POS_W:0] POS_MAX = 9'sd127;
   localparam logic signed [POS_W:0] POS_MIN = -9'sd127;

   typedef logic [1:0]        state_type;
   typedef logic signed [1:0] step_type;

   localparam step_type STEP_NONE = 2'sb00;
   localparam step_type STEP_FWD  = 2'sb01;
   localparam step_type STEP_REV  = 2'sb11;

   // indexed [previous winner][new winner]
   localparam step_type STEP_TABLE [4][4] = '{
      '{STEP_NONE, STEP_REV,  STEP_FWD,  STEP_NONE},
      '{STEP_FWD,  STEP_NONE, STEP_NONE, STEP_REV },
      '{STEP_REV,  STEP_NONE, STEP_NONE, STEP_FWD },
      '{STEP_NONE, STEP_FWD,  STEP_REV,  STEP_NONE}
   };

   typedef struct packed {
      logic [TIME_W-1:0] time_ms;
      logic              x_pin_a;
      logic              x_pin_b;
      logic              y_pin_a;
      logic              y_pin_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x_position;
      logic signed [POS_W-1:0] y_position;
      logic                    x_moved;
      logic                    y_moved;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic                    moved;
   } axis_result_type;

endpackage

### rtl/dqdm_axis.sv
// One axis: sample gating, majority window, transition step and saturating position.
module dqdm_axis
   import dqdm_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic [TIME_W-1:0]     time_ms,
   input  logic                  pin_a,
   input  logic                  pin_b,
   input  logic [INTERVAL_W-1:0] interval,
   output axis_result_type       result
);

   localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int TALLY_W = $clog2(WINDOW_DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   state_type               window_ff [WINDOW_DEPTH];
   state_type               window_in [WINDOW_DEPTH];
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   state_type               prev_ff, prev_in;
   logic [TIME_W-1:0]       last_ff, last_in;
   logic signed [POS_W-1:0] count_ff, count_in;

   logic [TIME_W-1:0]       elapsed;
   logic                    due;
   logic [TALLY_W-1:0]      tally [4];
   state_type               win;
   step_type                step;
   logic signed [POS_W:0]   sum;
   logic signed [POS_W-1:0] clamped;

   always_comb begin
      elapsed = time_ms - last_ff;
      due     = elapsed >= TIME_W'(interval);

      window_in = window_ff;
      window_in[slot_ff] = {pin_a, pin_b};

      for (int s = 0; s < 4; s++) begin
         tally[s] = '0;
      end
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         tally[window_in[i]] = tally[window_in[i]] + TALLY_W'(1);
      end

      // ties go to the lowest state
      win = 2'd0;
      for (int s = 1; s < 4; s++) begin
         if (tally[s] > tally[win]) begin
            win = 2'(s);
         end
      end

      step = STEP_TABLE[prev_ff][win];
      sum  = (POS_W + 1)'(count_ff) + (POS_W + 1)'(step);
      if (sum > POS_MAX) begin
         clamped = POS_MAX[POS_W-1:0];
      end else if (sum < POS_MIN) begin
         clamped = POS_MIN[POS_W-1:0];
      end else begin
         clamped = sum[POS_W-1:0];
      end

      slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
      prev_in  = win;
      last_in  = time_ms;
      count_in = (step != STEP_NONE) ? clamped : count_ff;

      result.position = due ? count_in : count_ff;
      result.moved    = due && (step != STEP_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         slot_ff  <= '0;
         prev_ff  <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else if (update && due) begin
         window_ff <= window_in;
         slot_ff   <= slot_in;
         prev_ff   <= prev_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/dual_quadrature_decoder_majority_core.sv
// Top level of the dual quadrature decoder with majority-vote filtering.
//
// req channel: one transaction per pin sample carrying the millisecond tick
// and the A/B levels of the X and Y encoders. rsp channel: exactly one
// transaction per request with both saturated positions and moved flags.
// csr port: write-only sample interval, taken on any cycle csr_wr_en is high;
// change it only while no transaction is in flight.
//
// A request is held in an input register; the axis update runs between that
// register and the result register, which drives the response. One transaction
// per cycle is sustained while rsp_ready is high; the axis update (32-bit
// elapsed compare plus window vote and add) is combinational.
// When rsp_ready is low a valid result register holds, the input register still
// takes one more transaction, and req_ready falls only once both are full.
// Synchronous reset clears both axes (windows, slots, previous states, sample
// times and positions), empties the pipeline and sets the interval to 2 ms.
module dual_quadrature_decoder_majority_core
   import dqdm_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_wr_en,
   input  logic [INTERVAL_W-1:0] csr_wr_data
);

   logic                  in_valid_ff, in_valid_in;
   req_payload_type       in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_payload_type       out_data_ff, out_data_in;
   logic [INTERVAL_W-1:0] interval_ff;
   logic                  advance;
   axis_result_type       x_result, y_result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   dqdm_axis #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_x_axis (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .time_ms  (in_data_ff.time_ms),
      .pin_a    (in_data_ff.x_pin_a),
      .pin_b    (in_data_ff.x_pin_b),
      .interval (interval_ff),
      .result   (x_result)
   );

   dqdm_axis #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_y_axis (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .time_ms  (in_data_ff.time_ms),
      .pin_a    (in_data_ff.y_pin_a),
      .pin_b    (in_data_ff.y_pin_b),
      .interval (interval_ff),
      .result   (y_result)
   );

   always_comb begin
      in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_data_in.x_position = x_result.position;
      out_data_in.y_position = y_result.position;
      out_data_in.x_moved    = x_result.moved;
      out_data_in.y_moved    = y_result.moved;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         interval_ff  <= INTERVAL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

### rtl/dqdm_checker.sv
// Port-level checks for the dual quadrature decoder, bound to the top level.
module dqdm_checker
   import dqdm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_payload_type       rsp_data
);

   logic signed [POS_W-1:0] pos_floor;
   assign pos_floor = POS_MIN[POS_W-1:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.x_position >= pos_floor) &&
                    (rsp_data.y_position >= pos_floor))
      else $error("position below saturation limit");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request stalled with free output");

endmodule

bind dual_quadrature_decoder_majority_core dqdm_checker u_dqdm_checker (.*);

### test/dqdm_checker.sv
// Checker for the dual quadrature decoder: predicts each response and compares it.
`timescale 1ns / 100ps

module dqdm_scoreboard
   import dqdm_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_wr_en,
   input  logic [INTERVAL_W-1:0] csr_wr_data,
   output int                    errors,
   output int                    pending
);

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int TURN_FWD = 1;
   localparam int TURN_REV = -1;
   localparam int TURN_NONE = 0;
   localparam int REPORT_LIMIT = 10;

   logic [1:0]            vote_window [0:1][0:WINDOW_DEPTH-1];
   int unsigned           window_slot [0:1];
   logic [1:0]            prev_vote [0:1];
   logic [TIME_W-1:0]     last_sample [0:1];
   int                    axis_pos [0:1];
   logic [INTERVAL_W-1:0] interval_ms;
   rsp_payload_type       reports_due [$];

   // position of a state along the forward cycle 0 -> 2 -> 3 -> 1
   function automatic int cycle_rank(input logic [1:0] s);
      case (s)
         2'd0: return 0;
         2'd2: return 1;
         2'd3: return 2;
         default: return 3;
      endcase
   endfunction

   function automatic int quadrature_turn(input logic [1:0] from, input logic [1:0] to);
      int diff;
      diff = (cycle_rank(to) - cycle_rank(from) + 4) % 4;
      if (diff == 1) return TURN_FWD;
      if (diff == 3) return TURN_REV;
      return TURN_NONE;
   endfunction

   function automatic logic advance_axis(input int ax, input logic [TIME_W-1:0] now,
                                         input logic [1:0] pins);
      int tally [0:3];
      logic [1:0] winner;
      logic [TIME_W-1:0] elapsed;
      int turn;
      for (int s = 0; s < 4; s++) tally[s] = 0;
      elapsed = now - last_sample[ax];
      if (elapsed < {{(TIME_W-INTERVAL_W){1'b0}}, interval_ms}) return 1'b0;
      last_sample[ax] = now;
      vote_window[ax][window_slot[ax]] = pins;
      window_slot[ax] = (window_slot[ax] + 1) % WINDOW_DEPTH;
      for (int i = 0; i < WINDOW_DEPTH; i++) tally[vote_window[ax][i]]++;
      winner = 2'd0;
      for (int s = 1; s < 4; s++) begin
         if (tally[s] > tally[winner]) winner = s[1:0];
      end
      turn = quadrature_turn(prev_vote[ax], winner);
      prev_vote[ax] = winner;
      if (turn == TURN_NONE) return 1'b0;
      axis_pos[ax] = axis_pos[ax] + turn;
      if (axis_pos[ax] > 127) axis_pos[ax] = 127;
      if (axis_pos[ax] < -127) axis_pos[ax] = -127;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      logic mx;
      logic my;
      if (reset) begin
         for (int ax = 0; ax < 2; ax++) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) vote_window[ax][i] = 2'd0;
            window_slot[ax] = 0;
            prev_vote[ax] = 2'd0;
            last_sample[ax] = '0;
            axis_pos[ax] = 0;
         end
         interval_ms = INTERVAL_RESET;
         reports_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (reports_due.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected transaction: x=%0d y=%0d xm=%0b ym=%0b",
                           got.x_position, got.y_position, got.x_moved, got.y_moved);
            end else begin
               want = reports_due.pop_front();
               if (got.x_position !== want.x_position || got.y_position !== want.y_position ||
                   got.x_moved !== want.x_moved || got.y_moved !== want.y_moved) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("mismatch: exp x=%0d y=%0d xm=%0b ym=%0b",
                              want.x_position, want.y_position, want.x_moved, want.y_moved);
                     $display("          got x=%0d y=%0d xm=%0b ym=%0b",
                              got.x_position, got.y_position, got.x_moved, got.y_moved);
                  end
               end
            end
         end
         if (csr_wr_en) interval_ms = csr_wr_data;
         if (req_valid && req_ready) begin
            mx = advance_axis(AXIS_X, req_data.time_ms, {req_data.x_pin_a, req_data.x_pin_b});
            my = advance_axis(AXIS_Y, req_data.time_ms, {req_data.y_pin_a, req_data.y_pin_b});
            want.x_position = axis_pos[AXIS_X][POS_W-1:0];
            want.y_position = axis_pos[AXIS_Y][POS_W-1:0];
            want.x_moved = mx;
            want.y_moved = my;
            reports_due.push_back(want);
         end
      end
      pending = reports_due.size();
   end

endmodule

### test/tb_dual_quadrature_decoder_majority_core.sv
// Testbench top for the dual quadrature decoder: stimulus, clocking and verdict.
`timescale 1ns / 100ps

module tb_dual_quadrature_decoder_majority_core
   import dqdm_pkg::*;
;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PERCENT = 14;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [INTERVAL_W-1:0] csr_wr_data = '0;
   int                    errors;
   int                    pending;
   int                    cycles = 0;
   logic                  calm = 1'b0;
   logic [TIME_W-1:0]     now_ms = '0;
   int                    walk_x = 0;
   int                    walk_y = 0;
   int                    dir_x = 1;
   int                    dir_y = -1;

   dual_quadrature_decoder_majority_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dqdm_scoreboard u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .pending     (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // pin levels {a, b} for a step count along the forward cycle
   function automatic logic [1:0] encoder_pins(input int step);
      case (step & 3)
         0: return 2'b00;
         1: return 2'b10;
         2: return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   task automatic offer(input logic [TIME_W-1:0] t, input logic [1:0] xs, input logic [1:0] ys);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_data <= '{time_ms: t, x_pin_a: xs[1], x_pin_b: xs[0], y_pin_a: ys[1], y_pin_b: ys[0]};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_interval(input logic [INTERVAL_W-1:0] iv);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= iv;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [INTERVAL_W-1:0] iv, input int count, input int quiet);
      int r;
      logic [1:0] xs;
      logic [1:0] ys;
      set_interval(iv);
      for (int k = 0; k < count; k++) begin
         calm = (k < quiet);
         r = $urandom_range(99);
         if (r < 8) now_ms = $urandom();
         else if (r < 20) now_ms = now_ms + iv;
         else if (r < 25) now_ms = now_ms - $urandom_range(0, 3);
         else now_ms = now_ms + $urandom_range(0, iv + iv / 2 + 1);
         if ($urandom_range(249) == 0) dir_x = -dir_x;
         if ($urandom_range(249) == 0) dir_y = -dir_y;
         if ($urandom_range(99) < 45) walk_x += dir_x;
         if ($urandom_range(99) < 45) walk_y += dir_y;
         xs = ($urandom_range(99) < 8) ? 2'($urandom()) : encoder_pins(walk_x);
         ys = ($urandom_range(99) < 8) ? 2'($urandom()) : encoder_pins(walk_y);
         offer(now_ms, xs, ys);
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      offer(32'd0, 2'b00, 2'b00);
      offer(32'd1, 2'b10, 2'b01);
      offer(32'd2, 2'b10, 2'b01);
      offer(32'd3, 2'b10, 2'b01);
      offer(32'd4, 2'b10, 2'b01);
      offer(32'hFFFF_FFFF, 2'b11, 2'b11);
      offer(32'd1, 2'b11, 2'b11);
      offer(32'd2, 2'b00, 2'b10);

      set_interval(8'd0);
      for (int k = 0; k < 12; k++) offer(32'd7, encoder_pins(k / 2), encoder_pins(-(k / 2)));

      set_interval(8'd255);
      offer(32'd261, 2'b01, 2'b01);
      offer(32'd262, 2'b01, 2'b01);
      offer(32'd0, 2'b01, 2'b01);
      offer(32'd255, 2'b00, 2'b11);

      run_phase(8'd0, 400, 150);
      run_phase(8'd1, 150, 0);
      run_phase(8'd255, 120, 0);
      run_phase(8'd2, 150, 0);
      run_phase(8'($urandom_range(4, 254)), 150, 0);
      run_phase(8'd3, 150, 0);
      run_phase(8'd0, 100, 0);

      drain();
      if (errors == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
